// ----- src/sssi2c_pkg.sv -----
package sssi2c_pkg;

   localparam logic [7:0] ADDR_RESET     = 8'b01000000;
   localparam logic [7:0] PORT0_CMD      = 8'h02;
   localparam logic [7:0] BLANK_SELECT   = 8'd255;
   localparam logic [7:0] BLANK_SEGMENTS = 8'h00;
   localparam int         STEP_BITS      = 3;

   // reciprocal of ten, exact for values below 43690
   localparam logic [16:0] RECIP_TEN  = 17'd52429;
   localparam int          RECIP_SHIFT = 19;

   typedef enum logic [2:0] {
      SRC_ADDR,
      SRC_CMD,
      SRC_BLANK_SEL,
      SRC_BLANK_SEG,
      SRC_SELECT,
      SRC_DIGIT
   } byte_src_type;

   typedef struct packed {
      byte_src_type src;
      logic         start;
      logic         stop;
      logic         div;
      logic         fin;
   } ctl_word_type;

   function automatic ctl_word_type ucode(input logic [STEP_BITS-1:0] step);
      ctl_word_type w;
      w = '{src: SRC_ADDR, start: 1'b0, stop: 1'b0, div: 1'b0, fin: 1'b0};
      unique case (step)
         3'd0: w = '{src: SRC_ADDR,      start: 1'b1, stop: 1'b0, div: 1'b1, fin: 1'b0};
         3'd1: w = '{src: SRC_CMD,       start: 1'b0, stop: 1'b0, div: 1'b1, fin: 1'b0};
         3'd2: w = '{src: SRC_BLANK_SEL, start: 1'b0, stop: 1'b0, div: 1'b1, fin: 1'b0};
         3'd3: w = '{src: SRC_BLANK_SEG, start: 1'b0, stop: 1'b0, div: 1'b1, fin: 1'b0};
         3'd4: w = '{src: SRC_ADDR,      start: 1'b1, stop: 1'b0, div: 1'b1, fin: 1'b0};
         3'd5: w = '{src: SRC_CMD,       start: 1'b0, stop: 1'b0, div: 1'b1, fin: 1'b0};
         3'd6: w = '{src: SRC_SELECT,    start: 1'b0, stop: 1'b0, div: 1'b1, fin: 1'b0};
         3'd7: w = '{src: SRC_DIGIT,     start: 1'b0, stop: 1'b1, div: 1'b0, fin: 1'b1};
         default: w = '{src: SRC_ADDR, start: 1'b0, stop: 1'b0, div: 1'b0, fin: 1'b0};
      endcase
      return w;
   endfunction

   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] p;
      p = 8'h00;
      case (digit)
         4'd0: p = 8'b00111111;
         4'd1: p = 8'b00000110;
         4'd2: p = 8'b01011011;
         4'd3: p = 8'b01001111;
         4'd4: p = 8'b01100110;
         4'd5: p = 8'b01101101;
         4'd6: p = 8'b01111101;
         4'd7: p = 8'b00000111;
         4'd8: p = 8'b01111111;
         4'd9: p = 8'b01101111;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

endpackage

// ----- src/sssi2c_req_if.sv -----
interface sssi2c_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [9:0] sample;

   modport source (output valid, output opcode, output sample, input ready);
   modport sink (input valid, input opcode, input sample, output ready);
endinterface

// ----- src/sssi2c_rsp_if.sv -----
interface sssi2c_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] bus_byte;
   logic       start_before;
   logic       stop_after;
   logic       last;

   modport source (output valid, output bus_byte, output start_before, output stop_after,
                   output last, input ready);
   modport sink (input valid, input bus_byte, input start_before, input stop_after,
                 input last, output ready);
endinterface

// ----- src/sssi2c_csr_if.sv -----
interface sssi2c_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/seven_segment_scan_i2c_sequencer.sv -----
// Scan driver for a four-digit seven-segment display behind a bus expander.
// req_ch carries items: opcode 1 stores a new sample to show (no response),
// opcode 0 is a display tick that yields eight bus bytes on rsp_ch: a
// blanking transaction (address, 0x02, 0xff, 0x00), then after a repeated
// start the address, 0x02, the digit select byte and the segment pattern.
// start_before marks bytes 0 and 4, stop_after and last mark byte 7.
// csr_ch writes the expander address byte; it is always ready.
// Sample and tick items are taken only when no tick run is active. A tick
// starts a run; its first byte is loaded into the output register once
// the run is under way, and the bytes follow at one per cycle, one
// microcode step per byte, while rsp_ch does not stall.
// The decimal digit is found during the first seven steps by a shared
// divide-by-ten unit, one division per step.
// When rsp_ch stalls, the byte stays in the output register and the step
// counter holds. Reset (synchronous) sets the address to 0x40, clears the
// shown value and scan position and drops all valid outputs.
module seven_segment_scan_i2c_sequencer
   import sssi2c_pkg::*;
#(
   parameter int DIGIT_COUNT = 4,
   parameter int SAMPLE_BITS = 10
) (
   input  logic          clock,
   input  logic          reset,
   sssi2c_req_if.sink    req_ch,
   sssi2c_rsp_if.source  rsp_ch,
   sssi2c_csr_if.sink    csr_ch
);

   localparam int PW = SAMPLE_BITS + 20;
   localparam int RW = SAMPLE_BITS + 4;

   logic [7:0]             addr_ff, addr_in;
   logic [SAMPLE_BITS-1:0] shown_ff, shown_in;
   logic [1:0]             scan_ff, scan_in;
   logic                   busy_ff, busy_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [SAMPLE_BITS-1:0] work_ff, work_in;
   logic [1:0]             count_ff, count_in;
   logic [3:0]             digit_ff, digit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   start_ff, start_in;
   logic                   stop_ff, stop_in;
   logic                   last_ff, last_in;

   ctl_word_type           ctl;
   logic                   adv;
   logic                   req_take;
   logic [SAMPLE_BITS+9:0] sample_ext;
   logic [PW-1:0]          prod;
   logic [SAMPLE_BITS-1:0] quot;
   logic [RW-1:0]          rem_wide;
   logic [7:0]             select_byte;
   logic [2:0]             scan_next;

   assign req_ch.ready = !busy_ff;
   assign csr_ch.ready = 1'b1;
   assign req_take     = req_ch.valid && !busy_ff;
   assign adv          = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign ctl          = ucode(step_ff);

   assign sample_ext = {{SAMPLE_BITS{1'b0}}, req_ch.sample};

   // divide by ten through the reciprocal, remainder by shift, add and subtract
   assign prod     = PW'(work_ff) * PW'(RECIP_TEN);
   assign quot     = SAMPLE_BITS'(prod >> RECIP_SHIFT);
   assign rem_wide = RW'(work_ff) - ((RW'(quot) << 3) + (RW'(quot) << 1));

   assign select_byte = ~(8'd1 << (3'd7 - {1'b0, scan_ff}));
   assign scan_next   = {1'b0, scan_ff} + 3'd1;

   always_comb begin
      addr_in      = addr_ff;
      shown_in     = shown_ff;
      scan_in      = scan_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      work_in      = work_ff;
      count_in     = count_ff;
      digit_in     = digit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      byte_in      = byte_ff;
      start_in     = start_ff;
      stop_in      = stop_ff;
      last_in      = last_ff;

      if (csr_ch.valid) begin
         addr_in = csr_ch.data;
      end

      if (req_take) begin
         if (req_ch.opcode) begin
            shown_in = sample_ext[SAMPLE_BITS-1:0];
         end else begin
            busy_in  = 1'b1;
            step_in  = '0;
            work_in  = shown_ff;
            count_in = scan_ff;
         end
      end

      if (adv) begin
         rsp_valid_in = 1'b1;
         start_in     = ctl.start;
         stop_in      = ctl.stop;
         last_in      = ctl.fin;
         case (ctl.src)
            SRC_ADDR:      byte_in = addr_ff;
            SRC_CMD:       byte_in = PORT0_CMD;
            SRC_BLANK_SEL: byte_in = BLANK_SELECT;
            SRC_BLANK_SEG: byte_in = BLANK_SEGMENTS;
            SRC_SELECT:    byte_in = select_byte;
            SRC_DIGIT:     byte_in = seg_pattern(digit_ff);
            default:       byte_in = 8'h00;
         endcase
         if (ctl.div) begin
            digit_in = rem_wide[3:0];
            if (count_ff != 2'd0) begin
               work_in  = quot;
               count_in = count_ff - 2'd1;
            end
         end
         if (ctl.fin) begin
            busy_in = 1'b0;
            scan_in = (32'(scan_next) >= DIGIT_COUNT) ? 2'd0 : scan_next[1:0];
         end else begin
            step_in = step_ff + STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= ADDR_RESET;
         shown_ff     <= '0;
         scan_ff      <= 2'd0;
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         shown_ff     <= shown_in;
         scan_ff      <= scan_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      count_ff <= count_in;
      digit_ff <= digit_in;
      byte_ff  <= byte_in;
      start_ff <= start_in;
      stop_ff  <= stop_in;
      last_ff  <= last_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.bus_byte     = byte_ff;
   assign rsp_ch.start_before = start_ff;
   assign rsp_ch.stop_after   = stop_ff;
   assign rsp_ch.last         = last_ff;

endmodule
